[rtl/tcmf_pkg.sv]
// tcmf_pkg: shared widths, register indexes, reset values and types
// for the two-channel median filter; depends on nothing
`timescale 1ns / 1ps

package tcmf_pkg;

  localparam int TEMP_W     = 16;
  localparam int MOIS_W     = 16;
  localparam int WINDOW_DEF = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOIS_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOIS_MAX = 2'd3;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST = -16'sd400;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST = 16'sd850;
  localparam logic [MOIS_W-1:0]        MOIS_MIN_RST = 16'd0;
  localparam logic [MOIS_W-1:0]        MOIS_MAX_RST = 16'd1000;

  typedef struct packed {
    logic clear;
    logic push;
  } sort_ctrl_t;

endpackage

[rtl/tcmf_ram.sv]
// tcmf_ram: generic one-write one-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module tcmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 5,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tcmf_sorter.sv]
// tcmf_sorter: insertion sorter, one value per cycle, with median taps
// depends on tcmf_pkg for the control struct
`timescale 1ns / 1ps

module tcmf_sorter #(
  parameter int WIDTH     = 16,
  parameter int DEPTH     = 5,
  parameter bit IS_SIGNED = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcmf_pkg::sort_ctrl_t ctrl,
  input  logic [WIDTH-1:0]    din,
  output logic [WIDTH-1:0]    med
);

  localparam int MID = DEPTH / 2;

  logic [WIDTH-1:0] val_r   [DEPTH];
  logic [WIDTH-1:0] val_nxt [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic [DEPTH-1:0] gt;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      if (IS_SIGNED) begin
        gt[k] = !vld_r[k] || ($signed(val_r[k]) > $signed(din));
      end else begin
        gt[k] = !vld_r[k] || (val_r[k] > din);
      end
    end
    for (int k = 0; k < DEPTH; k++) begin
      if (!gt[k]) begin
        val_nxt[k] = val_r[k];
      end else if (k == 0) begin
        val_nxt[k] = din;
      end else if (!gt[(k > 0) ? k-1 : 0]) begin
        val_nxt[k] = din;
      end else begin
        val_nxt[k] = val_r[(k > 0) ? k-1 : 0];
      end
      vld_nxt[k] = vld_r[k] || (k == 0) || ((k > 0) && vld_r[(k > 0) ? k-1 : 0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.clear) begin
      vld_r <= '0;
    end else if (ctrl.push) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      for (int k = 0; k < DEPTH; k++) begin
        val_r[k] <= val_nxt[k];
      end
    end
  end

  generate
    if ((DEPTH % 2) == 0) begin : g_even
      logic [WIDTH:0] sum;
      always_comb begin
        if (IS_SIGNED) begin
          sum = {val_r[MID-1][WIDTH-1], val_r[MID-1]} + {val_r[MID][WIDTH-1], val_r[MID]};
        end else begin
          sum = {1'b0, val_r[MID-1]} + {1'b0, val_r[MID]};
        end
      end
      assign med = sum[WIDTH:1];
    end else begin : g_odd
      assign med = val_r[MID];
    end
  endgenerate

endmodule

[rtl/two_channel_median_filter_with_check.sv]
// Two-channel sliding-window median filter with a range check on each raw pair.
// The window for both channels sits in one RAM; each item is written at a shared
// write position, then, once the window has filled, the RAM is read back one
// entry a cycle through its single read port into a pair of insertion sorters
// whose middle taps give the median (floor of the mean of the two middle values
// for an even window). The first WINDOW items pass through raw; after that each
// item goes through the states S_READ, S_MED and S_PUSH, its pace set by the
// one-entry-per-cycle readback (the default window is 5). in_stall is high while
// an item is in work; a finished result waits in the output register, so the
// next item is taken while the previous result is still held. sample_valid is
// high when both raw values lie within their configured ranges and the pair is
// not both zero. cfg_ready is always high; write configuration only while idle.
// Depends on tcmf_pkg, tcmf_ram and tcmf_sorter.
`timescale 1ns / 1ps

module two_channel_median_filter_with_check #(
  parameter int WINDOW = tcmf_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [tcmf_pkg::TEMP_W-1:0] in_temp_raw,
  input  logic [tcmf_pkg::MOIS_W-1:0]        in_mois_raw,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tcmf_pkg::TEMP_W-1:0] out_temp_filtered,
  output logic [tcmf_pkg::MOIS_W-1:0]        out_mois_filtered,
  output logic                               out_sample_valid,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tcmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TW = tcmf_pkg::TEMP_W;
  localparam int MW = tcmf_pkg::MOIS_W;
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] WIN_C  = CW'(WINDOW);
  localparam logic [CW-1:0] LAST_C = CW'(WINDOW - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MED  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [AW-1:0]          wpos_r, wpos_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [CW-1:0]          rd_cnt_r, rd_cnt_nxt;
  logic                   rd_vld_r;
  logic signed [TW-1:0]   temp_min_r, temp_max_r;
  logic [MW-1:0]          mois_min_r, mois_max_r;
  logic [TW-1:0]          res_temp_r;
  logic [MW-1:0]          res_mois_r;
  logic                   res_valid_r;
  logic                   out_valid_r;
  logic signed [TW-1:0]   out_temp_r;
  logic [MW-1:0]          out_mois_r;
  logic                   out_flag_r;

  logic                   in_xfer;
  logic                   out_free;
  logic                   range_ok;
  logic [TW+MW-1:0]       rd_data;
  logic [TW-1:0]          temp_med;
  logic [MW-1:0]          mois_med;
  tcmf_pkg::sort_ctrl_t   sort_ctrl;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_temp_filtered = out_temp_r;
  assign out_mois_filtered = out_mois_r;
  assign out_sample_valid  = out_flag_r;

  assign range_ok = (in_temp_raw >= temp_min_r) && (in_temp_raw <= temp_max_r) &&
                    (in_mois_raw >= mois_min_r) && (in_mois_raw <= mois_max_r) &&
                    !((in_temp_raw == '0) && (in_mois_raw == '0));

  assign sort_ctrl.clear = in_xfer && (fill_r == WIN_C);
  assign sort_ctrl.push  = rd_vld_r;

  tcmf_ram #(
    .WIDTH (TW + MW),
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_win_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wpos_r),
    .wdata ({in_temp_raw, in_mois_raw}),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (rd_data)
  );

  tcmf_sorter #(
    .WIDTH     (TW),
    .DEPTH     (WINDOW),
    .IS_SIGNED (1'b1)
  ) u_temp_sort (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (sort_ctrl),
    .din   (rd_data[TW+MW-1:MW]),
    .med   (temp_med)
  );

  tcmf_sorter #(
    .WIDTH     (MW),
    .DEPTH     (WINDOW),
    .IS_SIGNED (1'b0)
  ) u_mois_sort (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (sort_ctrl),
    .din   (rd_data[MW-1:0]),
    .med   (mois_med)
  );

  always_comb begin
    state_nxt  = state_r;
    wpos_nxt   = wpos_r;
    fill_nxt   = fill_r;
    rd_cnt_nxt = rd_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          wpos_nxt = (wpos_r == LAST_C[AW-1:0]) ? '0 : wpos_r + 1'b1;
          rd_cnt_nxt = '0;
          if (fill_r != WIN_C) begin
            fill_nxt  = fill_r + 1'b1;
            state_nxt = S_PUSH;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (rd_cnt_r != WIN_C) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end else begin
          state_nxt = S_MED;
        end
      end
      S_MED: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wpos_r      <= '0;
      fill_r      <= '0;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      temp_min_r  <= tcmf_pkg::TEMP_MIN_RST;
      temp_max_r  <= tcmf_pkg::TEMP_MAX_RST;
      mois_min_r  <= tcmf_pkg::MOIS_MIN_RST;
      mois_max_r  <= tcmf_pkg::MOIS_MAX_RST;
    end else begin
      state_r  <= state_nxt;
      wpos_r   <= wpos_nxt;
      fill_r   <= fill_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      rd_vld_r <= (state_r == S_READ) && (rd_cnt_r != WIN_C);
      if ((state_r == S_PUSH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcmf_pkg::CFG_TEMP_MIN: temp_min_r <= cfg_data;
          tcmf_pkg::CFG_TEMP_MAX: temp_max_r <= cfg_data;
          tcmf_pkg::CFG_MOIS_MIN: mois_min_r <= cfg_data;
          tcmf_pkg::CFG_MOIS_MAX: mois_max_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // result holding and output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_temp_r  <= in_temp_raw;
      res_mois_r  <= in_mois_raw;
      res_valid_r <= range_ok;
    end else if (state_r == S_MED) begin
      res_temp_r <= temp_med;
      res_mois_r <= mois_med;
    end
    if ((state_r == S_PUSH) && out_free) begin
      out_temp_r <= res_temp_r;
      out_mois_r <= res_mois_r;
      out_flag_r <= res_valid_r;
    end
  end

endmodule
